### rtl/sbr_pkg.sv
// ============================================================================
// sbr_pkg
// Shared types and constants of the stack blur block.
// ============================================================================
package sbr_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int MAX_RADIUS  = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // item kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LINE,
        S_INIT_RD,
        S_INIT_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RD_LO,
        S_RD_NEXT,
        S_RD_HI,
        S_RD_CUR,
        S_CAP,
        S_WR,
        S_LINE_END,
        S_DONE
    } t_state;

    // which sample position the address path forms
    typedef enum logic [2:0] {
        TAP_INIT,   // window fill, offset d
        TAP_LO,     // k - r, leaves the outgoing half
        TAP_NEXT,   // k + 1, moves from incoming to outgoing half
        TAP_HI,     // k + r + 1, enters the window
        TAP_CUR     // k, output position
    } t_tap;

    // clamped configuration
    typedef struct packed {
        logic [7:0] width;
        logic [7:0] height;
        logic [5:0] radius;
    } t_cfg;

    // host access to the pixel store
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [31:0]      data;
    } t_host;

    // controller to datapath
    typedef struct packed {
        logic run_start;
        logic line_start;
        logic pass_next;
        logic line_next;
        logic rd;
        t_tap tap;
        logic div_start;
        logic wr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic d_last;
        logic k_last;
        logic line_last;
        logic col;
        logic div_busy;
    } t_stat;

endpackage

### rtl/stack_blur_rgb.sv
// ============================================================================
// stack_blur_rgb
// Stack blur of an ARGB image held in an internal 16384-pixel store.
// ============================================================================
// Write and read words are accepted only while the sequencer is idle and the
// result queue has room for every result in flight. A read result comes from
// the pixel store's registered read port and then enters the result queue, and
// up to two results are buffered toward the output. A run word occupies the
// block for two passes: per line a window fill, then per pixel a divider start,
// a divider wait, four serial store reads, a capture and a write-back, since
// every store access goes through the single read port of each store.
// Alpha is kept.
// ============================================================================
module stack_blur_rgb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pixel_index[13:0], pixel_value[45:14]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_pixel[31:0]
    output logic [0:0]  m_axis_tuser    // blur_done[0]
);

    logic [7:0] r_width, r_height;
    logic [5:0] r_radius;
    logic       r_pend, r_pend_rd;
    logic [1:0] r_cnt, n_cnt;
    logic [32:0] r_q [2];
    logic [32:0] n_q [2];

    sbr_pkg::t_cfg  w_cfg;
    sbr_pkg::t_host w_host;
    sbr_pkg::t_cmd  w_cmd;
    sbr_pkg::t_stat w_stat;
    logic           w_idle, w_done_push, w_accept, w_pop;
    logic [31:0]    w_rd_data;
    logic [32:0]    w_push_word;
    sbr_pkg::t_kind w_kind;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 8'(sbr_pkg::MAX_WIDTH);
            r_height <= 8'(sbr_pkg::MAX_HEIGHT);
            r_radius <= 6'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbr_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                sbr_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                sbr_pkg::REG_RADIUS: r_radius <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // clamp dimensions and radius
    always_comb begin
        w_cfg.width  = r_width == 8'd0 ? 8'd1
                     : (r_width > 8'(sbr_pkg::MAX_WIDTH) ? 8'(sbr_pkg::MAX_WIDTH) : r_width);
        w_cfg.height = r_height == 8'd0 ? 8'd1
                     : (r_height > 8'(sbr_pkg::MAX_HEIGHT) ? 8'(sbr_pkg::MAX_HEIGHT)
                                                          : r_height);
        w_cfg.radius = r_radius > 6'(sbr_pkg::MAX_RADIUS) ? 6'(sbr_pkg::MAX_RADIUS)
                                                          : r_radius;
    end

    // input handshake: room for every result in flight
    assign w_kind        = sbr_pkg::t_kind'(s_axis_tuser);
    assign s_axis_tready = w_idle && ((3'(r_cnt) + 3'(r_pend)) < 3'd2);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_host.we   = w_accept && w_kind == sbr_pkg::KIND_WRITE;
    assign w_host.idx  = s_axis_tdata[sbr_pkg::IDX_W-1:0];
    assign w_host.data = s_axis_tdata[sbr_pkg::IDX_W +: 32];

    // registered result flag for write, read and unknown words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_accept && w_kind != sbr_pkg::KIND_RUN;
        end
        r_pend_rd <= w_kind == sbr_pkg::KIND_READ;
    end

    // two-entry result queue
    assign w_pop       = (r_cnt != 2'd0) && m_axis_tready;
    assign w_push_word = w_done_push ? {1'b1, 32'd0}
                                     : {1'b0, (r_pend_rd ? w_rd_data : 32'd0)};
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (w_pop) begin
            n_q[0] = r_q[1];
            n_cnt  = n_cnt - 2'd1;
        end
        if (r_pend || w_done_push) begin
            n_q[n_cnt[0]] = w_push_word;
            n_cnt         = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    assign m_axis_tvalid = r_cnt != 2'd0;
    assign m_axis_tdata  = r_q[0][31:0];
    assign m_axis_tuser  = r_q[0][32];

    sbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (w_accept && w_kind == sbr_pkg::KIND_RUN),
        .i_q_space   (r_cnt < 2'd2),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_done_push (w_done_push)
    );

    sbr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_host    (w_host),
        .i_idle    (w_idle),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_rd_data (w_rd_data)
    );

endmodule

### rtl/sbr_div.sv
// ============================================================================
// sbr_div
// Three-channel restoring divider, one quotient bit per cycle, 8-bit quotient.
// ============================================================================
module sbr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0][18:0]  i_dividend,
    input  logic [10:0]       i_divisor,
    output logic              o_busy,
    output logic [2:0][7:0]   o_quot
);

    logic             r_busy, n_busy;
    logic [2:0]       r_step, n_step;
    logic [2:0][18:0] r_rem, n_rem;
    logic [2:0][7:0]  r_quot, n_quot;
    logic [18:0]      w_shifted;

    // quotient is below 256, so eight trial subtractions suffice
    always_comb begin
        n_busy    = r_busy;
        n_step    = r_step;
        n_rem     = r_rem;
        n_quot    = r_quot;
        w_shifted = 19'(i_divisor) << r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 3'd7;
            n_rem  = i_dividend;
            n_quot = '0;
        end else if (r_busy) begin
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= w_shifted) begin
                    n_rem[c]          = r_rem[c] - w_shifted;
                    n_quot[c][r_step] = 1'b1;
                end
            end
            n_step = r_step - 3'd1;
            if (r_step == 3'd0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### rtl/sbr_dp.sv
// ============================================================================
// sbr_dp
// Blur datapath: pixel and row stores, address path, window sums, divider.
// ============================================================================
module sbr_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbr_pkg::t_cfg  i_cfg,
    input  sbr_pkg::t_host i_host,
    input  logic          i_idle,
    input  sbr_pkg::t_cmd  i_cmd,
    output sbr_pkg::t_stat o_stat,
    output logic [31:0]   o_rd_data
);

    // stores
    logic [31:0] r_pix_mem [sbr_pkg::STORE_DEPTH];
    logic [23:0] r_row_mem [sbr_pkg::STORE_DEPTH];
    logic [31:0] r_pix_q;
    logic [23:0] r_row_q;

    // line control
    logic                          r_col;
    logic [6:0]                    r_line;
    logic [6:0]                    r_k;
    logic signed [6:0]             r_d;
    logic [sbr_pkg::IDX_W-1:0]     r_base;
    logic [10:0]                   r_dsor;
    logic                          r_cap_vld;
    sbr_pkg::t_tap                 r_cap_tap;

    // window sums and taps
    logic [2:0][18:0] r_wsum;
    logic [2:0][13:0] r_osum;
    logic [2:0][13:0] r_isum;
    logic [23:0]      r_xa, r_xb, r_xc;
    logic [7:0]       r_alpha;

    logic [7:0]                w_len, w_nlines, w_stride;
    logic [6:0]                w_last;
    logic signed [9:0]         w_j;
    logic [6:0]                w_pos;
    logic [sbr_pkg::IDX_W-1:0] w_addr, w_pix_raddr;
    logic [23:0]               w_x, w_rgb;
    logic [5:0]                w_mag, w_wt;
    logic [2:0][7:0]           w_quot;
    logic                      w_div_busy;

    assign w_len    = r_col ? i_cfg.height : i_cfg.width;
    assign w_nlines = r_col ? i_cfg.width : i_cfg.height;
    assign w_stride = r_col ? i_cfg.width : 8'd1;
    assign w_last   = 7'(w_len - 8'd1);

    // sample position for the selected tap, clamped to the line
    always_comb begin
        case (i_cmd.tap)
            sbr_pkg::TAP_INIT: w_j = 10'(r_d);
            sbr_pkg::TAP_LO:   w_j = $signed({3'b0, r_k}) - $signed({4'b0, i_cfg.radius});
            sbr_pkg::TAP_NEXT: w_j = $signed({3'b0, r_k}) + 10'sd1;
            sbr_pkg::TAP_HI:   w_j = $signed({3'b0, r_k}) + $signed({4'b0, i_cfg.radius})
                                     + 10'sd1;
            default:           w_j = $signed({3'b0, r_k});
        endcase
        if (w_j < 10'sd0) begin
            w_pos = '0;
        end else if (w_j > $signed({3'b0, w_last})) begin
            w_pos = w_last;
        end else begin
            w_pos = w_j[6:0];
        end
        w_addr = r_base + sbr_pkg::IDX_W'(w_pos) * sbr_pkg::IDX_W'(w_stride);
    end

    assign w_pix_raddr = i_idle ? i_host.idx : w_addr;
    assign w_x         = r_col ? r_row_q : r_pix_q[23:0];
    assign w_mag       = r_d < 7'sd0 ? 6'(-r_d) : 6'(r_d);
    assign w_wt        = 6'(i_cfg.radius + 6'd1 - w_mag);
    assign w_rgb       = {w_quot[0], w_quot[1], w_quot[2]};

    // pixel store: host writes, column pass writes back with alpha kept
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_col) begin
            r_pix_mem[w_addr] <= {r_alpha, w_rgb};
        end else if (i_host.we) begin
            r_pix_mem[i_host.idx] <= i_host.data;
        end
        r_pix_q <= r_pix_mem[w_pix_raddr];
    end

    // row store: row pass writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !r_col) begin
            r_row_mem[w_addr] <= w_rgb;
        end
        r_row_q <= r_row_mem[w_addr];
    end

    // line, pass and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= 1'b0;
            r_line    <= '0;
            r_base    <= '0;
            r_cap_vld <= 1'b0;
        end else begin
            r_cap_vld <= i_cmd.rd;
            if (i_cmd.run_start) begin
                r_col  <= 1'b0;
                r_line <= '0;
                r_base <= '0;
            end else if (i_cmd.pass_next) begin
                r_col  <= 1'b1;
                r_line <= '0;
                r_base <= '0;
            end else if (i_cmd.line_next) begin
                r_line <= r_line + 7'd1;
                r_base <= r_base + (r_col ? sbr_pkg::IDX_W'(1)
                                          : sbr_pkg::IDX_W'(i_cfg.width));
            end
        end
        r_cap_tap <= i_cmd.tap;
    end

    // window sums, taps and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            r_osum <= '0;
            r_isum <= '0;
            r_k    <= '0;
            r_d    <= '0;
        end else if (i_cmd.line_start) begin
            r_wsum <= '0;
            r_osum <= '0;
            r_isum <= '0;
            r_k    <= '0;
            r_d    <= 7'(-$signed({1'b0, i_cfg.radius}));
        end else if (r_cap_vld && r_cap_tap == sbr_pkg::TAP_INIT) begin
            for (int c = 0; c < 3; c++) begin
                r_wsum[c] <= r_wsum[c] + 19'(w_x[23-8*c -: 8]) * 19'(w_wt);
                if (r_d > 7'sd0) begin
                    r_isum[c] <= r_isum[c] + 14'(w_x[23-8*c -: 8]);
                end else begin
                    r_osum[c] <= r_osum[c] + 14'(w_x[23-8*c -: 8]);
                end
            end
            r_d <= r_d + 7'sd1;
        end else if (i_cmd.wr) begin
            for (int c = 0; c < 3; c++) begin
                r_wsum[c] <= 19'(r_wsum[c] - 19'(r_osum[c]) + 19'(r_isum[c])
                                 + 19'(r_xc[23-8*c -: 8]));
                r_osum[c] <= 14'(r_osum[c] - 14'(r_xa[23-8*c -: 8])
                                 + 14'(r_xb[23-8*c -: 8]));
                r_isum[c] <= 14'(r_isum[c] + 14'(r_xc[23-8*c -: 8])
                                 - 14'(r_xb[23-8*c -: 8]));
            end
            r_k <= r_k + 7'd1;
        end
    end

    // tap capture from the registered store read of each tap
    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            case (r_cap_tap)
                sbr_pkg::TAP_LO:   r_xa    <= w_x;
                sbr_pkg::TAP_NEXT: r_xb    <= w_x;
                sbr_pkg::TAP_HI:   r_xc    <= w_x;
                sbr_pkg::TAP_CUR:  r_alpha <= r_pix_q[31:24];
                default: ;
            endcase
        end
        if (i_cmd.line_start) begin
            r_dsor <= 11'(i_cfg.radius + 6'd1) * 11'(i_cfg.radius + 6'd1);
        end
    end

    sbr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_wsum),
        .i_divisor  (r_dsor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign o_stat.d_last    = (r_d == $signed({1'b0, i_cfg.radius}));
    assign o_stat.k_last    = (r_k == w_last);
    assign o_stat.line_last = (r_line == 7'(w_nlines - 8'd1));
    assign o_stat.col       = r_col;
    assign o_stat.div_busy  = w_div_busy;
    assign o_rd_data        = r_pix_q;

endmodule

### rtl/sbr_ctrl.sv
// ============================================================================
// sbr_ctrl
// Sequencer of a blur run: window fill, divide, tap reads, write per pixel.
// ============================================================================
module sbr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_run,
    input  logic           i_q_space,
    input  sbr_pkg::t_stat i_stat,
    output sbr_pkg::t_cmd  o_cmd,
    output logic           o_idle,
    output logic           o_done_push
);

    sbr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbr_pkg::S_IDLE:     if (i_run) n_state = sbr_pkg::S_LINE;
            sbr_pkg::S_LINE:     n_state = sbr_pkg::S_INIT_RD;
            sbr_pkg::S_INIT_RD:  n_state = sbr_pkg::S_INIT_ACC;
            sbr_pkg::S_INIT_ACC: n_state = i_stat.d_last ? sbr_pkg::S_DIV_GO
                                                         : sbr_pkg::S_INIT_RD;
            sbr_pkg::S_DIV_GO:   n_state = sbr_pkg::S_DIV_WAIT;
            sbr_pkg::S_DIV_WAIT: if (!i_stat.div_busy) n_state = sbr_pkg::S_RD_LO;
            sbr_pkg::S_RD_LO:    n_state = sbr_pkg::S_RD_NEXT;
            sbr_pkg::S_RD_NEXT:  n_state = sbr_pkg::S_RD_HI;
            sbr_pkg::S_RD_HI:    n_state = sbr_pkg::S_RD_CUR;
            sbr_pkg::S_RD_CUR:   n_state = sbr_pkg::S_CAP;
            sbr_pkg::S_CAP:      n_state = sbr_pkg::S_WR;
            sbr_pkg::S_WR:       n_state = i_stat.k_last ? sbr_pkg::S_LINE_END
                                                         : sbr_pkg::S_DIV_GO;
            sbr_pkg::S_LINE_END: begin
                if (i_stat.line_last && i_stat.col) begin
                    n_state = sbr_pkg::S_DONE;
                end else begin
                    n_state = sbr_pkg::S_LINE;
                end
            end
            sbr_pkg::S_DONE:     if (i_q_space) n_state = sbr_pkg::S_IDLE;
            default:             n_state = sbr_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.tap   = sbr_pkg::TAP_CUR;
        o_idle      = 1'b0;
        o_done_push = 1'b0;
        case (r_state)
            sbr_pkg::S_IDLE: begin
                o_idle          = 1'b1;
                o_cmd.run_start = i_run;
            end
            sbr_pkg::S_LINE:    o_cmd.line_start = 1'b1;
            sbr_pkg::S_INIT_RD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = sbr_pkg::TAP_INIT;
            end
            sbr_pkg::S_DIV_GO:  o_cmd.div_start = 1'b1;
            sbr_pkg::S_RD_LO: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = sbr_pkg::TAP_LO;
            end
            sbr_pkg::S_RD_NEXT: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = sbr_pkg::TAP_NEXT;
            end
            sbr_pkg::S_RD_HI: begin
                o_cmd.rd  = 1'b1;
                o_cmd.tap = sbr_pkg::TAP_HI;
            end
            sbr_pkg::S_RD_CUR:  o_cmd.rd = 1'b1;
            sbr_pkg::S_WR:      o_cmd.wr = 1'b1;
            sbr_pkg::S_LINE_END: begin
                if (!i_stat.line_last) begin
                    o_cmd.line_next = 1'b1;
                end else if (!i_stat.col) begin
                    o_cmd.pass_next = 1'b1;
                end
            end
            sbr_pkg::S_DONE:    o_done_push = i_q_space;
            default: ;
        endcase
    end

endmodule

### tb/stack_blur_rgb_tb.sv
// ============================================================================
// stack_blur_rgb_tb
// Self-checking testbench of the stack blur block. Loads pixels, runs blurs
// and reads back over a series of image sizes and radii, comparing each result
// word with a behavioral predictor of the two-pass triangle-weighted filter.
// ============================================================================
module stack_blur_rgb_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 40;

    typedef struct {
        sbr_pkg::t_kind kind;
        logic [13:0]    idx;
        logic [31:0]    val;
    } t_word;

    typedef struct {
        logic [31:0] pixel;
        logic        done;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    stack_blur_rgb DUT (.*);

    // predictor state
    logic [31:0] pix_mem [sbr_pkg::STORE_DEPTH];
    logic [23:0] row_mem [sbr_pkg::STORE_DEPTH];
    int          img_w = 128, img_h = 128, img_r = 1;

    // stimulus bookkeeping
    bit          gen_written [sbr_pkg::STORE_DEPTH];
    t_word       pending_words [$];
    t_result     expected_results [$];
    int          send_idle = 0, recv_stall = 0;
    bit          in_acc = 1'b0;
    int          errors = 0;
    int          cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    // triangle-weighted window over one line, edges clamped
    function automatic logic [23:0] tri_filter(logic [23:0] s[$], int k, int r);
        int          c, d, p, last;
        int unsigned acc;
        logic [23:0] res;
        last = s.size() - 1;
        res = '0;
        for (c = 0; c < 3; c++) begin
            acc = 0;
            for (d = -r; d <= r; d++) begin
                p = k + d;
                if (p < 0) p = 0;
                if (p > last) p = last;
                acc += ((s[p] >> (16 - 8 * c)) & 8'hff) * (r + 1 - (d < 0 ? -d : d));
            end
            res |= (24'(acc / ((r + 1) * (r + 1))) << (16 - 8 * c));
        end
        return res;
    endfunction

    function automatic int clamp_dim(int v);
        return v < 1 ? 1 : (v > sbr_pkg::MAX_WIDTH ? sbr_pkg::MAX_WIDTH : v);
    endfunction

    // rows into the color store, then columns back into the pixel store
    task automatic blur_image();
        int          w, h, r, i, k;
        logic [23:0] line[$];
        w = clamp_dim(img_w);
        h = clamp_dim(img_h);
        r = img_r > sbr_pkg::MAX_RADIUS ? sbr_pkg::MAX_RADIUS : img_r;
        for (i = 0; i < h; i++) begin
            line.delete();
            for (k = 0; k < w; k++) line.push_back(pix_mem[i * w + k][23:0]);
            for (k = 0; k < w; k++) row_mem[i * w + k] = tri_filter(line, k, r);
        end
        for (i = 0; i < w; i++) begin
            line.delete();
            for (k = 0; k < h; k++) line.push_back(row_mem[k * w + i]);
            for (k = 0; k < h; k++)
                pix_mem[k * w + i] = {pix_mem[k * w + i][31:24], tri_filter(line, k, r)};
        end
    endtask

    // input side: a new word only once the last one was taken
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
        if (!s_axis_tvalid || in_acc) begin
            if (i_rst_n && pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, pending_words[0].val, pending_words[0].idx};
                s_axis_tuser  <= pending_words[0].kind;
                void'(pending_words.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_result        r;
        sbr_pkg::t_kind k;
        logic [13:0]    ix;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        in_acc = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_acc) begin
            k  = sbr_pkg::t_kind'(s_axis_tuser);
            ix = s_axis_tdata[13:0];
            r  = '{pixel: '0, done: 1'b0};
            case (k)
                sbr_pkg::KIND_WRITE: pix_mem[ix] = s_axis_tdata[45:14];
                sbr_pkg::KIND_RUN: begin
                    blur_image();
                    r.done = 1'b1;
                end
                sbr_pkg::KIND_READ: r.pixel = pix_mem[ix];
                default: ;
            endcase
            expected_results.push_back(r);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word: read_pixel %h blur_done %b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                r = expected_results.pop_front();
                if (m_axis_tdata !== r.pixel) begin
                    $error("read_pixel: expected %h, got %h", r.pixel, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== r.done) begin
                    $error("blur_done: expected %b, got %b", r.done, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    task automatic push_word(sbr_pkg::t_kind k, int idx, logic [31:0] v);
        pending_words.push_back('{kind: k, idx: 14'(idx), val: v});
        if (k == sbr_pkg::KIND_WRITE) gen_written[idx] = 1'b1;
    endtask

    task automatic write_reg(logic [1:0] index, int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= 8'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            sbr_pkg::REG_WIDTH:  img_w = value & 8'hff;
            sbr_pkg::REG_HEIGHT: img_h = value & 8'hff;
            sbr_pkg::REG_RADIUS: img_r = value & 6'h3f;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // let all words drain, then give the block time to go idle
    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // fill the region, then a random mix with a few runs
    task automatic random_phase(int n);
        int area, j, ix;
        area = clamp_dim(img_w) * clamp_dim(img_h);
        for (j = 0; j < area; j++)
            if (!gen_written[j]) push_word(sbr_pkg::KIND_WRITE, j, $urandom());
        for (j = 0; j < n; j++) begin
            case ($urandom_range(99)) inside
                [0:39]:  push_word(sbr_pkg::KIND_WRITE, $urandom_range(area - 1), $urandom());
                [40:47]: push_word(sbr_pkg::KIND_WRITE,
                                   $urandom_range(sbr_pkg::STORE_DEPTH - 1), $urandom());
                [48:85]: begin
                    ix = $urandom_range(sbr_pkg::STORE_DEPTH - 1);
                    if (!gen_written[ix]) ix = $urandom_range(area - 1);
                    push_word(sbr_pkg::KIND_READ, ix, $urandom());
                end
                [86:89]: push_word(sbr_pkg::KIND_NONE,
                                   $urandom_range(sbr_pkg::STORE_DEPTH - 1), $urandom());
                default: push_word(sbr_pkg::KIND_RUN,
                                   $urandom_range(sbr_pkg::STORE_DEPTH - 1), $urandom());
            endcase
        end
        push_word(sbr_pkg::KIND_RUN, 0, '0);
        for (j = 0; j < 4; j++) push_word(sbr_pkg::KIND_READ, $urandom_range(area - 1), '0);
    endtask

    initial begin
        int cfg_w [7] = '{3, 128, 1, 0, 255, 1, 8};
        int cfg_h [7] = '{2, 1, 128, 0, 1, 200, 8};
        int cfg_r [7] = '{0, 32, 63, 5, 1, 0, 2};
        int p;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: store extremes, reads, unknown kind
        push_word(sbr_pkg::KIND_WRITE, 0, 32'h0000_0000);
        push_word(sbr_pkg::KIND_WRITE, sbr_pkg::STORE_DEPTH - 1, 32'hffff_ffff);
        push_word(sbr_pkg::KIND_WRITE, 14'h2aaa, 32'ha5a5_5a5a);
        push_word(sbr_pkg::KIND_WRITE, 14'h1555, 32'h5a5a_a5a5);
        push_word(sbr_pkg::KIND_READ, sbr_pkg::STORE_DEPTH - 1, '0);
        push_word(sbr_pkg::KIND_READ, 0, 32'hffff_ffff);
        push_word(sbr_pkg::KIND_READ, 14'h2aaa, '0);
        push_word(sbr_pkg::KIND_READ, 14'h1555, '0);
        push_word(sbr_pkg::KIND_NONE, sbr_pkg::STORE_DEPTH - 1, 32'hffff_ffff);
        push_word(sbr_pkg::KIND_WRITE, 0, 32'h80ff_0001);
        push_word(sbr_pkg::KIND_READ, 0, '0);
        drain();

        for (p = 0; p < 27; p++) begin
            if (p < 7) begin
                write_reg(sbr_pkg::REG_WIDTH, cfg_w[p]);
                write_reg(sbr_pkg::REG_HEIGHT, cfg_h[p]);
                write_reg(sbr_pkg::REG_RADIUS, cfg_r[p]);
            end else begin
                write_reg(sbr_pkg::REG_WIDTH, $urandom_range(1, 8));
                write_reg(sbr_pkg::REG_HEIGHT, $urandom_range(1, 8));
                write_reg(sbr_pkg::REG_RADIUS, $urandom_range(63));
            end
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            random_phase(p < 7 ? 12 : 30);
            drain();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
